// File: rtl/core/tof_distance_window_average_core_macros.svh
// Assertion macros used by the core's back end (tdwa_back).
`ifndef TOF_DISTANCE_WINDOW_AVERAGE_CORE_MACROS_SVH
`define TOF_DISTANCE_WINDOW_AVERAGE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TDWA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TDWA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TDWA_ASSERT(lbl, prop, msg)
`define TDWA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/tdwa_pkg.sv
// Types and constants of the time-of-flight distance window averaging core.
package tdwa_pkg;

   localparam int DATA_W         = 32;
   localparam int SPEED_W        = 16;
   localparam int USED_W         = 8;
   localparam int PROD_W         = 49;
   localparam int ROUND_SHIFT    = 8;
   localparam int WINDOW_DEFAULT = 128;
   localparam int QUEUE_DEPTH    = 2;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd2248;

   typedef struct packed {
      logic [DATA_W-1:0] arrival_time;
      logic [DATA_W-1:0] launch_time;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] distance;
      logic signed [DATA_W-1:0] average_distance;
      logic [USED_W-1:0]        used_entries;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic full;
   } qwr_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_DIV,
      BK_DONE
   } bk_state_type;

endpackage

// File: rtl/core/tdwa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tdwa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tdwa_fifo.sv
// Small register queue with show-ahead read data.
module tdwa_fifo
   import tdwa_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/core/tdwa_front.sv
// Front end: accepts measurements, scales elapsed time to a saturated distance.
module tdwa_front
   import tdwa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  req_type                  req_data,
   input  logic                     csr_valid,
   input  logic [SPEED_W-1:0]       csr_speed_scale,
   output qwr_type                  mid_wr,
   input  logic                     mid_full,
   output logic signed [DATA_W-1:0] mid_distance
);

   logic [SPEED_W-1:0]       speed_ff, speed_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0]        elapsed;
   logic signed [PROD_W-1:0] rounded;
   logic [PROD_W-1-DATA_W+1:0] high_bits;
   logic                     accept;

   assign full    = s1_valid_ff & mid_full;
   assign accept  = push & ~full;
   assign elapsed = req_data.arrival_time - req_data.launch_time;

   always_comb begin
      speed_in    = csr_valid ? csr_speed_scale : speed_ff;
      s1_valid_in = accept | (s1_valid_ff & mid_full);
      prod_in     = prod_ff;
      if (accept) begin
         prod_in = $signed(elapsed) * $signed({1'b0, speed_ff});
      end
   end

   always_comb begin
      rounded   = (prod_ff + PROD_W'(128)) >>> ROUND_SHIFT;
      high_bits = rounded[PROD_W-1:DATA_W-1];
      if ((high_bits == '0) || (high_bits == '1)) begin
         mid_distance = rounded[DATA_W-1:0];
      end else if (rounded[PROD_W-1]) begin
         mid_distance = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         mid_distance = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   assign mid_wr.push = s1_valid_ff & ~mid_full;
   assign mid_wr.full = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= SPEED_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         speed_ff    <= speed_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/core/tdwa_back.sv
// Back end: updates the distance ring and running total, divides out the mean.
`include "tof_distance_window_average_core_macros.svh"
module tdwa_back
   import tdwa_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     mid_empty,
   output logic                     mid_pop,
   input  logic signed [DATA_W-1:0] mid_distance,
   output logic                     out_push,
   input  logic                     out_full,
   output rsp_type                  out_data
);

   localparam int AW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);
   localparam int TW = DATA_W + $clog2(WINDOW);
   localparam int SW = $clog2(TW);

   bk_state_type             st_ff, st_in;
   logic signed [DATA_W-1:0] dist_ff, dist_in;
   logic [AW-1:0]            wpos_ff, wpos_in;
   logic                     wrapped_ff, wrapped_in;
   logic signed [TW-1:0]     total_ff, total_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [TW-1:0]            quo_ff, quo_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic [SW-1:0]            step_ff, step_in;
   logic                     neg_ff, neg_in;
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [DATA_W-1:0]        ram_rd_data;
   logic signed [DATA_W-1:0] old_dist;
   logic [CW:0]              trial;
   logic [TW-1:0]            quo_signed;
   logic [CW+USED_W-1:0]     cnt_ext;

   tdwa_ram #(
      .WIDTH(DATA_W),
      .DEPTH(WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(wpos_ff),
      .wr_data(dist_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(wpos_ff),
      .rd_data(ram_rd_data)
   );

   assign old_dist = wrapped_ff ? $signed(ram_rd_data) : '0;
   assign trial    = {rem_ff, quo_ff[TW-1]};

   always_comb begin
      st_in      = st_ff;
      dist_in    = dist_ff;
      wpos_in    = wpos_ff;
      wrapped_in = wrapped_ff;
      total_in   = total_ff;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      neg_in     = neg_ff;
      mid_pop    = 1'b0;
      ram_rd_en  = 1'b0;
      ram_wr_en  = 1'b0;
      out_push   = 1'b0;
      unique case (st_ff)
         BK_IDLE: begin
            if (!mid_empty) begin
               mid_pop   = 1'b1;
               ram_rd_en = 1'b1;
               dist_in   = mid_distance;
               st_in     = BK_READ;
            end
         end
         BK_READ: begin
            ram_wr_en = 1'b1;
            total_in  = total_ff - TW'(old_dist) + TW'(dist_ff);
            cnt_in    = cnt_ff - CW'(old_dist != '0) + CW'(dist_ff != '0);
            if (wpos_ff == AW'(WINDOW - 1)) begin
               wpos_in    = '0;
               wrapped_in = 1'b1;
            end else begin
               wpos_in = wpos_ff + 1'b1;
            end
            neg_in  = total_in[TW-1];
            quo_in  = total_in[TW-1] ? -total_in : total_in;
            rem_in  = '0;
            step_in = '0;
            st_in   = (cnt_in == '0) ? BK_DONE : BK_DIV;
         end
         BK_DIV: begin
            if (trial >= {1'b0, cnt_ff}) begin
               rem_in = CW'(trial - {1'b0, cnt_ff});
               quo_in = {quo_ff[TW-2:0], 1'b1};
            end else begin
               rem_in = trial[CW-1:0];
               quo_in = {quo_ff[TW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(TW - 1)) begin
               st_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_full) begin
               out_push = 1'b1;
               st_in    = BK_IDLE;
            end
         end
         default: begin
            st_in = BK_IDLE;
         end
      endcase
   end

   assign quo_signed = neg_ff ? -quo_ff : quo_ff;
   assign cnt_ext    = (CW + USED_W)'(cnt_ff);

   assign out_data.distance         = dist_ff;
   assign out_data.average_distance = quo_signed[DATA_W-1:0];
   assign out_data.used_entries     = cnt_ext[USED_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= BK_IDLE;
         wpos_ff    <= '0;
         wrapped_ff <= 1'b0;
         total_ff   <= '0;
         cnt_ff     <= '0;
      end else begin
         st_ff      <= st_in;
         wpos_ff    <= wpos_in;
         wrapped_ff <= wrapped_in;
         total_ff   <= total_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
   end

   `TDWA_ASSERT(a_count_bound, (cnt_ff <= CW'(WINDOW)), "Nonzero count exceeds the window.")
   `TDWA_ASSERT(a_empty_total, ((cnt_ff == '0) |-> (total_ff == '0)), "Empty window has a total.")
   `TDWA_ASSERT(a_div_nonzero, ((st_ff == BK_DIV) |-> (cnt_ff != '0)), "Division by a zero count.")
   `TDWA_ASSERT(a_div_exit, ((st_ff == BK_DIV) |=> (st_ff == BK_DIV || st_ff == BK_DONE)),
      "Division left without finishing.")

endmodule

// File: rtl/core/tof_distance_window_average_core.sv
// Top level of the time-of-flight distance window averaging core.
//
//   Channel   Ports                              Transfer when
//   request   push, full, req_data               push && !full
//   response  empty, pop, rsp_data               pop && !empty
//   csr       csr_valid, csr_ready, csr_speed_scale  csr_valid && csr_ready
//
// The bit-serial mean divider of the back end runs TW = 32 + log2(WINDOW) steps,
// one quotient bit per step, and is skipped when no window entry is nonzero.
// The front end registers the product and hands the distance to a two-entry queue.
// Reset is synchronous; the ring reads as zero until its first full pass.
// Two responses may wait unread before the back end and then the request side stall.
module tof_distance_window_average_core
   import tdwa_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  req_type            req_data,
   output logic               empty,
   input  logic               pop,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SPEED_W-1:0] csr_speed_scale
);

   qwr_type                  mid_wr;
   logic                     mid_full;
   logic                     mid_empty;
   logic                     mid_pop;
   logic signed [DATA_W-1:0] front_distance;
   logic [DATA_W-1:0]        mid_rd_data;
   logic                     out_push;
   logic                     out_full;
   rsp_type                  out_data;
   logic [$bits(rsp_type)-1:0] rsp_vec;

   assign csr_ready = 1'b1;

   tdwa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .csr_valid      (csr_valid),
      .csr_speed_scale(csr_speed_scale),
      .mid_wr         (mid_wr),
      .mid_full       (mid_full),
      .mid_distance   (front_distance)
   );

   tdwa_fifo #(
      .WIDTH(DATA_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_mid_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (mid_wr.push),
      .full   (mid_full),
      .wr_data(front_distance),
      .pop    (mid_pop),
      .empty  (mid_empty),
      .rd_data(mid_rd_data)
   );

   tdwa_back #(
      .WINDOW(WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .mid_empty   (mid_empty),
      .mid_pop     (mid_pop),
      .mid_distance($signed(mid_rd_data)),
      .out_push    (out_push),
      .out_full    (out_full),
      .out_data    (out_data)
   );

   tdwa_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_out_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (out_push),
      .full   (out_full),
      .wr_data(out_data),
      .pop    (pop),
      .empty  (empty),
      .rd_data(rsp_vec)
   );

   assign rsp_data = rsp_vec;

endmodule
